### hw/rtl/dcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcf_pkg;

    // Operation codes carried in the low bits of the input tdata
    localparam logic [2:0] OP_ENQUEUE = 3'd0;
    localparam logic [2:0] OP_DEQUEUE = 3'd1;
    localparam logic [2:0] OP_MARK    = 3'd2;
    localparam logic [2:0] OP_FLUSH   = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    // Status codes reported with every result
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam int CMD_W   = 4;
    localparam int FLAGS_W = 5;
    localparam int FILL_W  = 5;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [FLAGS_W-1:0] t_flags;

    // One-hot pending flag of a code; zero for codes without a flag
    function automatic t_flags flag_mask(input t_cmd code);
        t_flags m;
        case (code)
            4'd0:    m = 5'b00001;
            4'd1:    m = 5'b00010;
            4'd5:    m = 5'b00100;
            4'd6:    m = 5'b01000;
            4'd7:    m = 5'b10000;
            default: m = 5'b00000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/dedup_command_fifo_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Command queue with duplicate suppression for codes 0, 1, 5, 6 and 7. Each input
// transfer carries one operation and yields exactly one result transfer. Enqueue,
// mark handled, query, unknown opcodes and a dequeue or flush of an empty queue
// finish in the accepting cycle, so their result is registered at that edge.
// Dequeue reads the head entry from the synchronous entry RAM when accepted and
// registers its result from the RAM output in the S_DEQ state. Flush drains the
// queue through the same RAM read port, one entry per cycle to clear each drained
// code's pending flag, and registers its result in the S_FLUSH state once the last
// entry's flag is cleared. Input is taken only while the unit is idle and the
// output register is empty or its result transfers in the same cycle. fill_count
// reports the low 5 bits of the entry count.
module dedup_command_fifo_unit
    import dcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [2:0] opcode, [6:3] command, [7] zero
    input  wire logic [7:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [1:0] status, [5:2] out_command, [6] is_pending, [11:7] fill_count, [15:12] zero
    output logic [15:0]      o_m_axis_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_FLUSH
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    t_flags          r_flags, n_flags;
    t_cmd            r_cmd, n_cmd;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_out_status, n_out_status;
    t_cmd            r_out_cmd, n_out_cmd;
    logic            r_out_pend, n_out_pend;
    logic [FILL_W-1:0] r_out_fill, n_out_fill;

    logic            in_fire;
    logic [2:0]      in_op;
    t_cmd            in_cmd;
    t_flags          in_mask;
    logic            wr_en;
    logic            rd_en;
    t_cmd            rd_data;

    assign in_op   = i_s_axis_tdata[2:0];
    assign in_cmd  = i_s_axis_tdata[6:3];
    assign in_mask = flag_mask(in_cmd);

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_fill, r_out_pend, r_out_cmd, r_out_status};

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    // Entry storage: write at tail, read at head
    dcf_entry_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (CMD_W)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (in_cmd),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    // Operation sequencing and result formation
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_flags      = r_flags;
        n_cmd        = r_cmd;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_cmd    = r_out_cmd;
        n_out_pend   = r_out_pend;
        n_out_fill   = r_out_fill;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_out_status = ST_DONE;
                    n_out_cmd    = '0;
                    n_out_valid  = 1'b1;
                    case (in_op)
                        OP_ENQUEUE: begin
                            if ((r_flags & in_mask) != '0) begin
                                n_out_status = ST_DUP;
                            end else if (r_count == FULL_CNT) begin
                                n_flags      = r_flags & ~in_mask;
                                n_out_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_tail  = next_idx(r_tail);
                                n_count = r_count + CW'(1);
                                n_flags = r_flags | in_mask;
                            end
                        end
                        OP_DEQUEUE: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                rd_en       = 1'b1;
                                n_head      = next_idx(r_head);
                                n_count     = r_count - CW'(1);
                                n_cmd       = in_cmd;
                                n_out_valid = 1'b0;
                                n_state     = S_DEQ;
                            end
                        end
                        OP_MARK: begin
                            n_flags = r_flags & ~in_mask;
                        end
                        OP_FLUSH: begin
                            if (r_count != '0) begin
                                rd_en       = 1'b1;
                                n_head      = next_idx(r_head);
                                n_count     = r_count - CW'(1);
                                n_cmd       = in_cmd;
                                n_out_valid = 1'b0;
                                n_state     = S_FLUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_pend = |(n_flags & in_mask);
                    n_out_fill = FILL_W'(n_count);
                end
            end
            S_DEQ: begin
                // head entry now on the RAM read port
                n_out_valid  = 1'b1;
                n_out_status = ST_DONE;
                n_out_cmd    = rd_data;
                n_out_pend   = |(r_flags & flag_mask(r_cmd));
                n_out_fill   = FILL_W'(r_count);
                n_state      = S_IDLE;
            end
            S_FLUSH: begin
                // clear the flag of the drained entry, then fetch the next one or, with none left, give the result
                n_flags = r_flags & ~flag_mask(rd_data);
                if (r_count != '0) begin
                    rd_en   = 1'b1;
                    n_head  = next_idx(r_head);
                    n_count = r_count - CW'(1);
                end else begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_DONE;
                    n_out_cmd    = '0;
                    n_out_pend   = |(n_flags & flag_mask(r_cmd));
                    n_out_fill   = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_out_status <= n_out_status;
        r_out_cmd    <= n_out_cmd;
        r_out_pend   <= n_out_pend;
        r_out_fill   <= n_out_fill;
    end

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above queue depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count == '0) |-> (r_head == r_tail))
        else $error("head and tail differ on empty queue");

    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && r_count == '0) |=>
            (r_state == S_IDLE && r_count == '0 && r_out_valid))
        else $error("flush did not end empty with a result");

    a_deq_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ) |=> (r_state == S_IDLE && r_out_valid))
        else $error("dequeue did not deliver its result");

endmodule

`default_nettype wire

### hw/rtl/dcf_entry_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dcf_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### sim/dedup_command_fifo_unit_tb.sv
`timescale 1ns / 1ps

module dedup_command_fifo_unit_tb;
    import dcf_pkg::*;

    localparam int DEPTH      = 16;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 40;

    // Opcodes the block ignores
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // Codes that own a pending flag
    localparam t_cmd FLAGGED [5] = '{4'd0, 4'd1, 4'd5, 4'd6, 4'd7};

    typedef struct packed {
        logic [1:0]        status;
        t_cmd              out_cmd;
        logic              pending;
        logic [FILL_W-1:0] fill;
    } t_reply;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_valid  = 1'b0;
    logic [7:0]  s_data   = 8'd0;
    logic        m_ready  = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;

    // Pending input words and replies still owed by the block
    logic [7:0] op_backlog [$];
    t_reply     reply_q [$];

    // Shadow of the queue contents and flags
    t_cmd              shadow_store [DEPTH];
    logic [3:0]        shadow_head;
    logic [3:0]        shadow_tail;
    logic [FILL_W-1:0] shadow_count;
    t_flags            shadow_flags;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int cycles = 0;
    int n_ops = 0;
    int n_flush = 0;
    int n_status [4] = '{0, 0, 0, 0};

    dedup_command_fifo_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Flag bit owned by a code, zero if it has none
    function automatic t_flags owner_bit(input t_cmd code);
        t_flags b;
        b = '0;
        if (code <= 4'd1)
            b[code] = 1'b1;
        else if (code >= 4'd5 && code <= 4'd7)
            b[code - 4'd3] = 1'b1;
        return b;
    endfunction

    // Apply one operation to the shadow queue and return the reply it owes
    function automatic t_reply queue_step(input logic [7:0] word);
        logic [2:0] op;
        t_cmd       cmd;
        t_flags     fbit;
        t_reply     r;
        op   = word[2:0];
        cmd  = word[6:3];
        fbit = owner_bit(cmd);
        r    = '0;
        r.status = ST_DONE;
        case (op)
            OP_ENQUEUE: begin
                if ((shadow_flags & fbit) != '0) begin
                    r.status = ST_DUP;
                end else if (shadow_count == DEPTH) begin
                    shadow_flags &= ~fbit;
                    r.status = ST_FULL;
                end else begin
                    shadow_store[shadow_tail] = cmd;
                    shadow_tail  = shadow_tail + 1'b1;
                    shadow_count = shadow_count + 1'b1;
                    shadow_flags |= fbit;
                end
            end
            OP_DEQUEUE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.out_cmd    = shadow_store[shadow_head];
                    shadow_head  = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            OP_MARK: shadow_flags &= ~fbit;
            OP_FLUSH: begin
                while (shadow_count != 0) begin
                    shadow_flags &= ~owner_bit(shadow_store[shadow_head]);
                    shadow_head  = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            default: ;
        endcase
        r.pending = ((shadow_flags & fbit) != '0);
        r.fill    = shadow_count;
        return r;
    endfunction

    // Input driver: predict on each accepted transfer, then offer the next word
    always @(posedge i_clk) begin
        logic taken;
        taken = s_valid && o_s_axis_tready;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (taken) begin
                reply_q.push_back(queue_step(s_data));
                n_ops++;
                if (s_data[2:0] == OP_FLUSH)
                    n_flush++;
            end
            if (!s_valid || taken) begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= op_backlog.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each reply transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        got = '{status:  o_m_axis_tdata[1:0],
                out_cmd: o_m_axis_tdata[5:2],
                pending: o_m_axis_tdata[6],
                fill:    o_m_axis_tdata[11:7]};
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (reply_q.size() == 0) begin
                if (err_count < 10)
                    $display("ERROR: unexpected reply %h", o_m_axis_tdata);
                err_count++;
            end else begin
                want = reply_q.pop_front();
                n_status[want.status]++;
                if (got != want) begin
                    if (err_count < 10)
                        $display("ERROR: reply status %0d/%0d cmd %0d/%0d pend %0d/%0d fill %0d/%0d (exp/act)",
                                 want.status, got.status, want.out_cmd, got.out_cmd,
                                 want.pending, got.pending, want.fill, got.fill);
                    err_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_op(input logic [2:0] op, input t_cmd cmd);
        op_backlog.push_back({1'b0, cmd, op});
    endtask

    // Half the time a flagged code, otherwise any code
    function automatic t_cmd pick_cmd();
        if ($urandom_range(1) == 0)
            return FLAGGED[$urandom_range(4)];
        return t_cmd'($urandom_range(15));
    endfunction

    // Random bursts: fills that run into full, drains that run dry, and mixed traffic
    task automatic load_random(input int n);
        int added;
        int len;
        int mode;
        int roll;
        logic [2:0] op;
        added = 0;
        while (added < n) begin
            mode = $urandom_range(2);
            len  = (mode == 0) ? $urandom_range(20, 8) : $urandom_range(18, 4);
            for (int k = 0; k < len; k++) begin
                if (mode == 0) begin
                    op = OP_ENQUEUE;
                end else if (mode == 1) begin
                    op = ($urandom_range(4) == 0) ? OP_QUERY : OP_DEQUEUE;
                end else begin
                    roll = $urandom_range(99);
                    if (roll < 35)      op = OP_ENQUEUE;
                    else if (roll < 60) op = OP_DEQUEUE;
                    else if (roll < 75) op = OP_MARK;
                    else if (roll < 85) op = OP_QUERY;
                    else if (roll < 90) op = OP_FLUSH;
                    else                op = 3'($urandom_range(7, 5));
                end
                push_op(op, pick_cmd());
            end
            added += len;
        end
    endtask

    // Hold the sender until every reply has arrived
    task automatic drain_all();
        while (op_backlog.size() != 0 || s_valid || reply_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        load_random(n);
        drain_all();
    endtask

    // Stimulus
    initial begin
        shadow_head  = '0;
        shadow_tail  = '0;
        shadow_count = '0;
        shadow_flags = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty cases, each flagged code, duplicates, mark, query, reserved opcodes, flush
        push_op(OP_DEQUEUE, 4'd15);
        push_op(OP_FLUSH,   4'd0);
        push_op(OP_ENQUEUE, 4'd0);
        push_op(OP_ENQUEUE, 4'd1);
        push_op(OP_ENQUEUE, 4'd5);
        push_op(OP_ENQUEUE, 4'd6);
        push_op(OP_ENQUEUE, 4'd7);
        push_op(OP_ENQUEUE, 4'd15);
        push_op(OP_ENQUEUE, 4'd15);
        push_op(OP_ENQUEUE, 4'd0);
        push_op(OP_QUERY,   4'd5);
        push_op(OP_MARK,    4'd5);
        push_op(OP_QUERY,   4'd5);
        push_op(OP_ENQUEUE, 4'd5);
        push_op(OP_MARK,    4'd10);
        push_op(OP_QUERY,   4'd10);
        push_op(OP_RSVD5,   4'd7);
        push_op(OP_RSVD6,   4'd8);
        push_op(OP_RSVD7,   4'd1);
        push_op(OP_DEQUEUE, 4'd0);
        push_op(OP_FLUSH,   4'd3);
        push_op(OP_QUERY,   4'd7);
        push_op(OP_DEQUEUE, 4'd6);
        drain_all();

        run_phase(0, 0, 100);
        run_phase(59, 0, 130);
        run_phase(0, 59, 130);
        run_phase(8, 8, 140);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (reply_q.size() != 0) begin
            $display("ERROR: %0d replies never arrived", reply_q.size());
            err_count++;
        end

        $display("Ran %0d operations (%0d flushes) under four handshake idle mixes",
                 n_ops, n_flush);
        $display("Replies seen: %0d done, %0d duplicate, %0d full, %0d empty; %0d mismatches",
                 n_status[ST_DONE], n_status[ST_DUP], n_status[ST_FULL],
                 n_status[ST_EMPTY], err_count);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/dcf_pkg.sv
hw/rtl/dcf_entry_ram.sv
hw/rtl/dedup_command_fifo_unit.sv
sim/dedup_command_fifo_unit_tb.sv
